// File: src/lcdseq_pkg.sv
package lcdseq_pkg;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic [1:0] line;
        logic [6:0] cell_req;
    } t_req;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_value;
        logic       enable;
        logic [5:0] hold_ms;
        logic       last;
    } t_step;

    // Request kinds.
    localparam logic [2:0] KIND_INSTR  = 3'd0;
    localparam logic [2:0] KIND_DATA   = 3'd1;
    localparam logic [2:0] KIND_INIT   = 3'd2;
    localparam logic [2:0] KIND_CURSOR = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    // Operation codes of a request's command list.
    localparam logic [1:0] OP_END  = 2'd0;
    localparam logic [1:0] OP_WAIT = 2'd1;
    localparam logic [1:0] OP_BYTE = 2'd2;
    localparam logic [1:0] OP_HOLD = 2'd3;

    // Display instructions.
    localparam logic [7:0] CMD_FUNC_8BIT = 8'h38;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LINE2_OFFSET  = 8'h40;

    localparam logic [5:0] HOLD_PULSE_MS = 6'd1;
    localparam logic [5:0] HOLD_INIT_MS  = 6'd50;

    localparam logic [1:0] LINE_ONE = 2'd1;
    localparam logic [1:0] LINE_TWO = 2'd2;

    // The pins during the wait after a clear: the last half of the clear pulse.
    localparam logic [7:0] HOLD_BUS_8BIT = CMD_CLEAR;
    localparam logic [7:0] HOLD_BUS_4BIT = {CMD_CLEAR[3:0], 4'b0000};

    typedef struct packed {
        logic [1:0] code;
        logic       rs;
        logic       use_req;   // byte comes from the request, not the list
        logic [7:0] cmd_byte;
    } t_op;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [2:0] idx;
        logic [1:0] sub;
    } t_ctl_cmd;

    typedef struct packed {
        logic cur_end;
        logic sub_done;
        logic last_step;
        logic out_free;
    } t_dp_status;

    function automatic t_op mk_op(logic [1:0] code, logic [7:0] b);
        t_op op;
        op.code     = code;
        op.rs       = 1'b0;
        op.use_req  = 1'b0;
        op.cmd_byte = b;
        return op;
    endfunction

    // Command list of a request, one operation per index.
    function automatic t_op op_at(logic [2:0] kind, logic mode, logic line_ok,
                                  logic [2:0] idx);
        t_op op;
        op = mk_op(OP_END, 8'h00);
        case (kind)
            KIND_INSTR, KIND_DATA, KIND_CURSOR: begin
                if (idx == 3'd0 && (kind != KIND_CURSOR || line_ok)) begin
                    op         = mk_op(OP_BYTE, 8'h00);
                    op.use_req = 1'b1;
                    op.rs      = (kind == KIND_DATA);
                end
            end
            KIND_INIT: begin
                if (mode) begin
                    case (idx)
                        3'd0:    op = mk_op(OP_WAIT, 8'h00);
                        3'd1:    op = mk_op(OP_BYTE, CMD_HOME);
                        3'd2:    op = mk_op(OP_BYTE, CMD_FUNC_4BIT);
                        3'd3:    op = mk_op(OP_BYTE, CMD_DISP_ON);
                        3'd4:    op = mk_op(OP_BYTE, CMD_CLEAR);
                        3'd5:    op = mk_op(OP_HOLD, 8'h00);
                        3'd6:    op = mk_op(OP_BYTE, CMD_ENTRY);
                        default: op = mk_op(OP_END, 8'h00);
                    endcase
                end else begin
                    case (idx)
                        3'd0:    op = mk_op(OP_WAIT, 8'h00);
                        3'd1:    op = mk_op(OP_BYTE, CMD_FUNC_8BIT);
                        3'd2:    op = mk_op(OP_BYTE, CMD_DISP_ON);
                        3'd3:    op = mk_op(OP_BYTE, CMD_CLEAR);
                        3'd4:    op = mk_op(OP_HOLD, 8'h00);
                        3'd5:    op = mk_op(OP_BYTE, CMD_ENTRY);
                        default: op = mk_op(OP_END, 8'h00);
                    endcase
                end
            end
            KIND_CLEAR: begin
                case (idx)
                    3'd0:    op = mk_op(OP_BYTE, CMD_CLEAR);
                    3'd1:    op = mk_op(OP_HOLD, 8'h00);
                    default: op = mk_op(OP_END, 8'h00);
                endcase
            end
            default: op = mk_op(OP_END, 8'h00);
        endcase
        return op;
    endfunction

endpackage

// File: src/lcdseq_if.sv
interface lcdseq_req_if;
    import lcdseq_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lcdseq_step_if;
    import lcdseq_pkg::*;
    logic  valid;
    logic  ready;
    t_step data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/lcdseq_ctrl.sv
module lcdseq_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    input  lcdseq_pkg::t_dp_status i_status,
    output lcdseq_pkg::t_ctl_cmd   o_cmd
);
    import lcdseq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic       r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic [1:0] r_sub, n_sub;
    logic       step;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_sub   = r_sub;
        step    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_RUN;
                    n_idx   = 3'd0;
                    n_sub   = 2'd0;
                end
            end
            S_RUN: begin
                if (i_status.cur_end) begin
                    // A request with an empty command list.
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    step = 1'b1;
                    if (i_status.last_step) begin
                        n_state = S_IDLE;
                    end else if (i_status.sub_done) begin
                        n_idx = r_idx + 3'd1;
                        n_sub = 2'd0;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 3'd0;
            r_sub   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
        end
    end

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_req_valid;
        o_cmd.step = step;
        o_cmd.idx  = r_idx;
        o_cmd.sub  = r_sub;
    end
endmodule

// File: src/lcdseq_dp.sv
module lcdseq_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  lcdseq_pkg::t_req       i_req,
    input  lcdseq_pkg::t_ctl_cmd   i_cmd,
    output lcdseq_pkg::t_dp_status o_status,
    output logic                   o_valid,
    input  logic                   i_ready,
    output lcdseq_pkg::t_step      o_step
);
    import lcdseq_pkg::*;

    logic       r_bus_mode;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic       r_line_ok;
    logic       r_valid;
    t_step      r_step;

    t_op        cur_op;
    t_op        next_op;
    logic [7:0] col;
    logic [7:0] req_byte;
    logic [7:0] wr_byte;
    logic       sub_done;
    t_step      n_step;

    // Set cursor address: column is one-based, wrapping at 256.
    assign col = {1'b0, i_req.cell_req} - 8'd1;

    always_comb begin
        if (i_req.kind == KIND_CURSOR) begin
            req_byte = CMD_SET_DDRAM | col;
            if (i_req.line == LINE_TWO) begin
                req_byte = req_byte | LINE2_OFFSET;
            end
        end else begin
            req_byte = i_req.byte_value;
        end
    end

    assign cur_op  = op_at(r_kind, r_bus_mode, r_line_ok, i_cmd.idx);
    assign next_op = op_at(r_kind, r_bus_mode, r_line_ok, i_cmd.idx + 3'd1);
    assign wr_byte = cur_op.use_req ? r_byte : cur_op.cmd_byte;

    // A byte is two beats in eight-bit mode and four in four-bit mode.
    assign sub_done = (cur_op.code != OP_BYTE) ||
                      (i_cmd.sub == (r_bus_mode ? 2'd3 : 2'd1));

    always_comb begin
        n_step.reg_select = 1'b0;
        n_step.bus_value  = 8'h00;
        n_step.enable     = 1'b0;
        n_step.hold_ms    = HOLD_PULSE_MS;
        n_step.last       = sub_done && (next_op.code == OP_END);
        case (cur_op.code)
            OP_WAIT: n_step.hold_ms = HOLD_INIT_MS;
            OP_HOLD: n_step.bus_value = r_bus_mode ? HOLD_BUS_4BIT : HOLD_BUS_8BIT;
            OP_BYTE: begin
                n_step.reg_select = cur_op.rs;
                n_step.enable     = ~i_cmd.sub[0];
                if (!r_bus_mode) begin
                    n_step.bus_value = wr_byte;
                end else if (i_cmd.sub[1]) begin
                    n_step.bus_value = {wr_byte[3:0], 4'b0000};
                end else begin
                    n_step.bus_value = {wr_byte[7:4], 4'b0000};
                end
            end
            default: n_step.last = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_mode <= 1'b1;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bus_mode <= i_cfg_wdata;
            end
            if (i_cmd.step) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_req.kind;
            r_byte    <= req_byte;
            r_line_ok <= (i_req.line == LINE_ONE) || (i_req.line == LINE_TWO);
        end
        if (i_cmd.step) begin
            r_step <= n_step;
        end
    end

    always_comb begin
        o_status.cur_end   = (cur_op.code == OP_END);
        o_status.sub_done  = sub_done;
        o_status.last_step = n_step.last;
        o_status.out_free  = !r_valid || i_ready;
    end

    assign o_valid = r_valid;
    assign o_step  = r_step;
endmodule

// File: src/char_lcd_bus_write_sequencer.sv
// Character LCD bus write sequencer.
// i_req takes one request (instruction, data byte, init, set cursor, clear);
// o_step gives the run of pin steps for it, one beat per step: register
// select, bus value, enable level, hold time in ms, and a last flag on the
// final step. i_cfg_we/i_cfg_wdata write bus_mode (0 eight-bit, 1 four-bit);
// write it only while no request is in progress.
// The request is taken while idle; its steps are then registered one by one
// into the output register, one step per cycle while the receiver takes them.
// A request with no steps (a set cursor on another line, an unknown kind)
// returns to idle without a step. The next request is accepted while the
// final step still waits in the output register. A command list gives 2 or
// 4 beats per byte, up to 22 steps for the four-bit init.
// Reset leaves the block idle, the output empty and bus_mode at four-bit.
// When the receiver stalls, the output register holds its step and the
// sequencer waits; nothing is dropped or repeated.
module char_lcd_bus_write_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    lcdseq_req_if.sink    i_req,
    lcdseq_step_if.source o_step
);
    import lcdseq_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    lcdseq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lcdseq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_step.valid),
        .i_ready     (o_step.ready),
        .o_step      (o_step.data)
    );
endmodule

// File: test/lcd_pin_step_checker.sv
module lcd_pin_step_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  logic   i_cfg_wdata,
    lcdseq_req_if  i_req,
    lcdseq_step_if i_step,
    output int     o_errors,
    output int     o_pending,
    output int     o_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    import lcdseq_pkg::*;

    logic  four_bit;
    t_step expected_pins[$];
    t_step pin_run[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_beats   = 0;
        four_bit  = 1'b1;
    end

    function automatic void add_pin(input logic rs, input logic [7:0] bus,
                                    input logic en, input logic [5:0] hold);
        t_step s;
        s.reg_select = rs;
        s.bus_value  = bus;
        s.enable     = en;
        s.hold_ms    = hold;
        s.last       = 1'b0;
        pin_run.push_back(s);
    endfunction

    function automatic void add_pulse(input logic rs, input logic [7:0] bus);
        add_pin(rs, bus, 1'b1, HOLD_PULSE_MS);
        add_pin(rs, bus, 1'b0, HOLD_PULSE_MS);
    endfunction

    function automatic void add_byte(input logic rs, input logic [7:0] b);
        if (four_bit) begin
            add_pulse(rs, {b[7:4], 4'h0});
            add_pulse(rs, {b[3:0], 4'h0});
        end else begin
            add_pulse(rs, b);
        end
    endfunction

    // The wait after a clear keeps the pins of the step before it, enable low.
    function automatic void add_hold();
        t_step prev;
        prev = pin_run[pin_run.size() - 1];
        add_pin(prev.reg_select, prev.bus_value, 1'b0, HOLD_PULSE_MS);
    endfunction

    function automatic void predict_pin_steps(input t_req r);
        logic [7:0] col;
        t_step      s;
        int         n;
        pin_run.delete();
        col = 8'(r.cell_req) - 8'd1;
        case (r.kind)
            KIND_INSTR: add_byte(1'b0, r.byte_value);
            KIND_DATA:  add_byte(1'b1, r.byte_value);
            KIND_INIT: begin
                add_pin(1'b0, 8'h00, 1'b0, HOLD_INIT_MS);
                if (four_bit) begin
                    add_byte(1'b0, CMD_HOME);
                    add_byte(1'b0, CMD_FUNC_4BIT);
                end else begin
                    add_byte(1'b0, CMD_FUNC_8BIT);
                end
                add_byte(1'b0, CMD_DISP_ON);
                add_byte(1'b0, CMD_CLEAR);
                add_hold();
                add_byte(1'b0, CMD_ENTRY);
            end
            KIND_CURSOR: begin
                if (r.line == LINE_ONE) begin
                    add_byte(1'b0, CMD_SET_DDRAM | col);
                end else if (r.line == LINE_TWO) begin
                    add_byte(1'b0, CMD_SET_DDRAM | LINE2_OFFSET | col);
                end
            end
            KIND_CLEAR: begin
                add_byte(1'b0, CMD_CLEAR);
                add_hold();
            end
            default: ;
        endcase
        n = pin_run.size();
        for (int k = 0; k < n; k++) begin
            s      = pin_run[k];
            s.last = (k == n - 1);
            expected_pins.push_back(s);
        end
    endfunction

    always @(posedge i_clk) begin
        t_step got;
        t_step want;
        if (!i_rst_n) begin
            four_bit = 1'b1;
        end else begin
            if (i_req.valid && i_req.ready) begin
                predict_pin_steps(i_req.data);
            end
            if (i_step.valid && i_step.ready) begin
                got     = i_step.data;
                o_beats = o_beats + 1;
                if (expected_pins.size() == 0) begin
                    o_errors = o_errors + 1;
                    $display({"%0t: unexpected beat: expected none, ",
                              "got rs=%0d bus=%02h en=%0d hold=%0d last=%0d"},
                             $time, got.reg_select, got.bus_value, got.enable,
                             got.hold_ms, got.last);
                end else begin
                    want = expected_pins.pop_front();
                    if (got.reg_select !== want.reg_select ||
                        got.bus_value !== want.bus_value ||
                        got.enable !== want.enable || got.hold_ms !== want.hold_ms ||
                        got.last !== want.last) begin
                        o_errors = o_errors + 1;
                        $display({"%0t: step mismatch: ",
                                  "expected rs=%0d bus=%02h en=%0d hold=%0d last=%0d, ",
                                  "got rs=%0d bus=%02h en=%0d hold=%0d last=%0d"},
                                 $time, want.reg_select, want.bus_value, want.enable,
                                 want.hold_ms, want.last, got.reg_select, got.bus_value,
                                 got.enable, got.hold_ms, got.last);
                    end
                end
            end
            // A mode write lands after any request accepted on the same edge.
            if (i_cfg_we) begin
                four_bit = i_cfg_wdata;
            end
        end
        o_pending = expected_pins.size();
    end

endmodule

// File: test/char_lcd_bus_write_sequencer_test.sv
module char_lcd_bus_write_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdseq_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_REQUESTS  = 52;
    localparam int FREE_RUN_PHASE  = 3;
    localparam int IDLE_PERCENT    = 36;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    lcdseq_req_if  req_bus ();
    lcdseq_step_if step_bus ();

    int mismatches;
    int pins_pending;
    int pins_seen;
    int cycle_count   = 0;
    int requests_sent = 0;
    int mode_writes   = 0;
    bit steady        = 1'b0;

    char_lcd_bus_write_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_step      (step_bus)
    );

    lcd_pin_step_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .i_step      (step_bus),
        .o_errors    (mismatches),
        .o_pending   (pins_pending),
        .o_beats     (pins_seen)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d pin steps outstanding.",
                     cycle_count, pins_pending);
            $display("char_lcd_bus_write_sequencer_test: FAIL");
            $finish;
        end
    end

    // The display side stalls at random except during the free-running phase.
    always @(negedge i_clk) begin
        step_bus.ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    function automatic t_req pack_request(input logic [2:0] kind, input logic [7:0] b,
                                          input logic [1:0] line, input logic [6:0] column);
        t_req r;
        r.kind       = kind;
        r.byte_value = b;
        r.line       = line;
        r.cell_req   = column;
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        r    = pack_request(KIND_INSTR, 8'($urandom), 2'($urandom), 7'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            r.kind = KIND_INSTR;
        end else if (pick < 50) begin
            r.kind = KIND_DATA;
        end else if (pick < 60) begin
            r.kind = KIND_INIT;
        end else if (pick < 82) begin
            r.kind = KIND_CURSOR;
            // Most cursor moves target a real line so they produce steps.
            if ($urandom_range(0, 99) < 80) begin
                r.line = $urandom_range(0, 1) ? LINE_TWO : LINE_ONE;
            end
        end else if (pick < 92) begin
            r.kind = KIND_CLEAR;
        end else begin
            r.kind = 3'(KIND_CLEAR + $urandom_range(1, 3));
        end
        return r;
    endfunction

    task automatic send_request(input t_req r);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            req_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid = 1'b1;
        req_bus.data  = r;
        @(posedge i_clk);
        while (!req_bus.ready) begin
            @(posedge i_clk);
        end
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Lets the block drain completely before the bus mode changes.
    task automatic settle_and_set_mode(input logic four);
        req_bus.valid = 1'b0;
        while (pins_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = four;
        mode_writes++;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic directed_run(input bit full);
        if (full) begin
            send_request(pack_request(KIND_INSTR, 8'h00, 2'd0, 7'd0));
            send_request(pack_request(KIND_INSTR, 8'hFF, 2'd3, 7'h7F));
            send_request(pack_request(KIND_DATA, 8'hA5, 2'd0, 7'd1));
            send_request(pack_request(KIND_DATA, 8'h5A, 2'd0, 7'd1));
            send_request(pack_request(KIND_INIT, 8'h00, 2'd0, 7'd1));
            send_request(pack_request(KIND_CURSOR, 8'h00, LINE_ONE, 7'd1));
            send_request(pack_request(KIND_CURSOR, 8'h00, LINE_TWO, 7'd64));
            send_request(pack_request(KIND_CURSOR, 8'h00, LINE_ONE, 7'd0));
            send_request(pack_request(KIND_CURSOR, 8'h00, LINE_TWO, 7'h7F));
            send_request(pack_request(KIND_CURSOR, 8'h00, 2'd0, 7'd5));
            send_request(pack_request(KIND_CURSOR, 8'h00, 2'd3, 7'd5));
            send_request(pack_request(KIND_CLEAR, 8'h00, 2'd0, 7'd1));
            send_request(pack_request(3'(KIND_CLEAR + 1), 8'h00, 2'd0, 7'd1));
            send_request(pack_request(3'(KIND_CLEAR + 3), 8'hFF, 2'd3, 7'h7F));
        end else begin
            send_request(pack_request(KIND_DATA, 8'hFF, 2'd0, 7'd1));
            send_request(pack_request(KIND_INSTR, 8'h00, 2'd0, 7'd1));
            send_request(pack_request(KIND_INIT, 8'h00, 2'd0, 7'd1));
            send_request(pack_request(KIND_CURSOR, 8'h00, LINE_TWO, 7'd0));
            send_request(pack_request(KIND_CURSOR, 8'h00, LINE_ONE, 7'd64));
            send_request(pack_request(KIND_CLEAR, 8'h00, 2'd0, 7'd1));
            send_request(pack_request(3'(KIND_CLEAR + 2), 8'h00, 2'd0, 7'd1));
        end
    endtask

    initial begin
        logic four;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        req_bus.valid  = 1'b0;
        req_bus.data   = '0;
        step_bus.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset leaves the four-bit bus selected.
        directed_run(1'b1);
        settle_and_set_mode(1'b0);
        directed_run(1'b0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            four = (phase < 4) ? ~phase[0] : 1'($urandom);
            settle_and_set_mode(four);
            steady = (phase == FREE_RUN_PHASE);
            repeat (PHASE_REQUESTS) send_request(random_request());
        end
        steady        = 1'b0;
        req_bus.valid = 1'b0;

        while (pins_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);

        $display("Sent %0d requests across %0d bus mode writes; %0d pin steps checked.",
                 requests_sent, mode_writes, pins_seen);
        $display("Covered both bus widths, init, clear, cursor on every line, odd kinds.");
        if (mismatches == 0 && pins_pending == 0) begin
            $display("char_lcd_bus_write_sequencer_test: PASS");
        end else begin
            $display("char_lcd_bus_write_sequencer_test: FAIL");
        end
        $finish;
    end

endmodule
